// File: design/ispl_pkg.sv
// shared types, codes and constants of the two-wire link master
package ispl_pkg;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_STOP  = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	localparam int BYTE_W = 8;
	localparam int STEP_W = 5;
	localparam int IN_DATA_W = 16;
	localparam int IN_USER_W = 3;
	localparam int OUT_DATA_W = 16;
	localparam int OUT_USER_W = 1;

	localparam logic [STEP_W-1:0] LEN_EDGE  = 5'd4;
	localparam logic [STEP_W-1:0] LEN_WRITE = 5'd17;
	localparam logic [STEP_W-1:0] LEN_READ  = 5'd18;
	localparam logic [STEP_W-1:0] BIT_STEPS = 5'd16;

	typedef struct packed {
		logic              cmd_valid;
		op_t               mode;
		logic [BYTE_W-1:0] byte_value;
		logic              sda_in;
	} item_t;

	typedef struct packed {
		op_t               op;
		logic [STEP_W-1:0] step;
		logic              busy;
		logic [BYTE_W-1:0] shift;
		logic              clk;
		logic              sda;
		logic              drv;
	} state_t;

	typedef struct packed {
		logic              clk_level;
		logic              sda_level;
		logic              sda_drive;
		logic              ready_res;
		logic              accepted;
		logic              read_done;
		logic [BYTE_W-1:0] read_byte;
	} result_t;

	function automatic logic [STEP_W-1:0] op_length(input op_t op);
		case (op)
			OP_WRITE: op_length = LEN_WRITE;
			OP_READ:  op_length = LEN_READ;
			default:  op_length = LEN_EDGE;
		endcase
	endfunction

endpackage

// File: design/ispl_in_stage.sv
// input register of the link master
module ispl_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ispl_pkg::item_t in_item,
	input  logic          advance,
	output logic          valid_s1,
	output ispl_pkg::item_t item_s1
);
	import ispl_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// File: design/ispl_engine.sv
// line sequencer: state registers and the per-tick step logic
module ispl_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  ispl_pkg::item_t item_s1,
	output ispl_pkg::result_t result
);
	import ispl_pkg::*;

	state_t            st_q;
	state_t            st_n;
	logic              take;
	logic              done;
	logic [STEP_W-1:0] cur_step;
	logic [STEP_W-1:0] step_inc;

	always_comb begin
		st_n = st_q;
		done = 1'b0;
		take = item_s1.cmd_valid && !st_q.busy;
		if (take) begin
			st_n.busy  = 1'b1;
			st_n.op    = item_s1.mode;
			st_n.step  = '0;
			st_n.shift = (item_s1.mode == OP_WRITE) ? item_s1.byte_value : '0;
		end
		cur_step = st_n.step;
		step_inc = cur_step + 5'd1;
		if (st_n.busy) begin
			case (st_n.op)
				OP_START: begin
					st_n.drv = 1'b1;
					case (cur_step)
						5'd0:    st_n.sda = 1'b1;
						5'd1:    st_n.clk = 1'b1;
						5'd2:    st_n.sda = 1'b0;
						default: st_n.clk = 1'b0;
					endcase
				end
				OP_STOP: begin
					st_n.drv = 1'b1;
					case (cur_step)
						5'd0:    st_n.clk = 1'b0;
						5'd1:    st_n.sda = 1'b0;
						5'd2:    st_n.clk = 1'b1;
						default: st_n.sda = 1'b1;
					endcase
				end
				OP_WRITE: begin
					st_n.drv = 1'b1;
					if (cur_step < BIT_STEPS) begin
						if (!cur_step[0]) begin
							st_n.clk = 1'b0;
							st_n.sda = st_n.shift[BYTE_W-1];
						end else begin
							st_n.clk   = 1'b1;
							st_n.shift = {st_n.shift[BYTE_W-2:0], 1'b0};
						end
					end else begin
						st_n.sda = 1'b0;
					end
				end
				default: begin
					if (cur_step < BIT_STEPS) begin
						st_n.drv = 1'b0;
						if (!cur_step[0]) begin
							st_n.clk   = 1'b1;
							st_n.shift = {st_n.shift[BYTE_W-2:0], item_s1.sda_in};
						end else begin
							st_n.clk = 1'b0;
						end
					end else if (cur_step == BIT_STEPS) begin
						st_n.drv = 1'b0;
						st_n.clk = 1'b0;
					end else begin
						st_n.clk = 1'b0;
						st_n.drv = 1'b1;
						st_n.sda = 1'b0;
						done     = 1'b1;
					end
				end
			endcase
			st_n.step = step_inc;
			if (step_inc >= op_length(st_n.op)) begin
				st_n.busy = 1'b0;
				st_n.step = '0;
			end
		end
	end

	always_comb begin
		result.clk_level = st_n.clk;
		result.sda_level = st_n.drv && st_n.sda;
		result.sda_drive = st_n.drv;
		result.ready_res = !st_n.busy;
		result.accepted  = take;
		result.read_done = done;
		result.read_byte = done ? st_n.shift : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.op    <= OP_START;
			st_q.step  <= '0;
			st_q.busy  <= 1'b0;
			st_q.shift <= '0;
			st_q.clk   <= 1'b1;
			st_q.sda   <= 1'b1;
			st_q.drv   <= 1'b1;
		end else if (advance) begin
			st_q <= st_n;
		end
	end

endmodule

// File: design/ispl_out_stage.sv
// result register of the link master
module ispl_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  ispl_pkg::result_t result,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              slot_free,
	output ispl_pkg::result_t result_q
);
	import ispl_pkg::*;

	assign slot_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (slot_free) begin
			out_valid <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

endmodule

// File: design/two_wire_isp_link_master.sv
// top level of the two-wire programming link master
// One input word is one timing tick of the link and yields exactly one result word.
// A word is taken every cycle while the result side is not stalled: it passes an input
// register, one step of the line sequencer and a result register, and the sequencer state
// advances once per tick. A start or stop spans four ticks, a byte write seventeen and
// a byte read eighteen; commands arriving while a sequence runs are dropped and
// reported with accepted low. Backpressure on the result side stalls the whole path.
module two_wire_isp_link_master (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// byte_value, sda_in, zero pad
	input  logic [ispl_pkg::IN_DATA_W-1:0]       s_tdata,
	// cmd_valid, mode
	input  logic [ispl_pkg::IN_USER_W-1:0]       s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// clk_level, sda_level, sda_drive, ready_res, accepted, read_byte, zero pad
	output logic [ispl_pkg::OUT_DATA_W-1:0]      m_tdata,
	// read_done
	output logic [ispl_pkg::OUT_USER_W-1:0]      m_tuser
);
	import ispl_pkg::*;

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    slot_free;
	logic    advance;
	result_t result;
	result_t result_q;

	assign in_item.cmd_valid  = s_tuser[0];
	assign in_item.mode       = op_t'(s_tuser[2:1]);
	assign in_item.byte_value = s_tdata[BYTE_W-1:0];
	assign in_item.sda_in     = s_tdata[BYTE_W];

	assign advance = valid_s1 && slot_free;

	ispl_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ispl_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.result  (result)
	);

	ispl_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.result    (result),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.slot_free (slot_free),
		.result_q  (result_q)
	);

	assign m_tdata = {3'b000, result_q.read_byte, result_q.accepted, result_q.ready_res,
		result_q.sda_drive, result_q.sda_level, result_q.clk_level};
	assign m_tuser = result_q.read_done;

`ifndef NO_ASSERTIONS
	a_empty_out_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	a_released_reads_low: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> !m_tdata[1])
		else $error("data level high while line released");

	a_accept_makes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> !m_tdata[3])
		else $error("command taken but ready still reported");

	a_read_end_lines: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[2] && !m_tdata[0] && !m_tdata[1] && !m_tdata[4])
		else $error("read completion with wrong line levels");
`endif

endmodule
